>>> rtl/core/positional_array_store_defines.svh
// ---------------------------------------------------------------------------
// Positional array store - assertion macros
// Shared concurrent assertion helpers; compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_STORE_DEFINES_SVH
`define POSITIONAL_ARRAY_STORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every rising clock edge outside reset
`define PAS_ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("positional_array_store: assertion failed");
// consequent must hold in the cycle after the antecedent
`define PAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional_array_store: assertion failed");
`else
`define PAS_ASSERT_ALWAYS(label, clk, rst_n, prop)
`define PAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/pas_pkg.sv
// ---------------------------------------------------------------------------
// Positional array store - package
// Sizes, codes and the item types shared by the block's modules.
// ---------------------------------------------------------------------------
package pas_pkg;

  // list storage
  localparam int DEPTH       = 32;
  localparam int MAX_RESULTS = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int OP_W      = 2;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 6;
  localparam int LIMIT_W   = 6;
  localparam int STATUS_W  = 3;
  localparam int OUT_IDX_W = 5;
  localparam int OUT_CNT_W = 6;

  // width wide enough to compare positions, counts and limits
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DUMP   = 2'd3
  } pas_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } pas_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DUMP
  } pas_state_e;

  typedef struct packed {
    pas_op_e                   op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } pas_cmd_t;

  typedef struct packed {
    pas_status_e               status;
    logic [OUT_IDX_W-1:0]      index;
    logic signed [VALUE_W-1:0] entry_value;
    logic [OUT_CNT_W-1:0]      entry_count;
    logic                      last;
  } pas_result_t;

endpackage

>>> rtl/core/pas_in_if.sv
// ---------------------------------------------------------------------------
// Positional array store - request channel
// Carries one operation item with valid/ready handshake.
// ---------------------------------------------------------------------------
interface pas_in_if;
  logic                               valid;
  logic                               ready;
  logic [pas_pkg::OP_W-1:0]           operation;
  logic signed [pas_pkg::VALUE_W-1:0] value;
  logic [pas_pkg::POS_W-1:0]          position;

  modport source (output valid, operation, value, position, input ready);
  modport sink   (input valid, operation, value, position, output ready);
endinterface

>>> rtl/core/pas_out_if.sv
// ---------------------------------------------------------------------------
// Positional array store - result channel
// Carries one result item with valid/ready handshake.
// ---------------------------------------------------------------------------
interface pas_out_if;
  logic                               valid;
  logic                               ready;
  logic [pas_pkg::STATUS_W-1:0]       status;
  logic [pas_pkg::OUT_IDX_W-1:0]      index;
  logic signed [pas_pkg::VALUE_W-1:0] entry_value;
  logic [pas_pkg::OUT_CNT_W-1:0]      entry_count;
  logic                               last;

  modport source (output valid, status, index, entry_value, entry_count, last,
                  input ready);
  modport sink   (input valid, status, index, entry_value, entry_count, last,
                  output ready);
endinterface

>>> rtl/core/pas_cfg_if.sv
// ---------------------------------------------------------------------------
// Positional array store - configuration write channel
// Writes the capacity limit register.
// ---------------------------------------------------------------------------
interface pas_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pas_pkg::LIMIT_W-1:0]    capacity_limit;

  modport source (output valid, capacity_limit, input ready);
  modport sink   (input valid, capacity_limit, output ready);
endinterface

>>> rtl/core/positional_array_store.sv
// ---------------------------------------------------------------------------
// Positional array store - top level
// Ordered list of signed 32-bit values with insert, delete, search and dump.
// ---------------------------------------------------------------------------
// Channels: in_i takes one operation item (operation, value, position);
// out_o returns result items; cfg_i writes capacity_limit (always ready).
// Every item yields one result with last set, except a dump of a non-empty
// list, which yields one result per entry (at most 32) with last on the end.
// Path: an accepted item passes the front register and the queue to the
// execution stage, whose result register holds its result; a search also
// passes the registered hit vector. Insert, delete and refused items run
// straight from idle; a search registers a compare of every cell, then the
// priority pick; a dump latches its length, then emits its entries in order.
// The execution sequencer handles one item at a time; the two-entry queue
// and front register keep accepting items meanwhile.
// Reset: the list is empty and the capacity limit is 32; entry cells are not
// cleared. When the receiver stalls, the result register holds its item,
// the sequencer waits, and the queue then fills and stalls the input.
// ---------------------------------------------------------------------------
module positional_array_store (
  input  logic     clk_i,
  input  logic     rst_ni,
  pas_in_if.sink   in_i,
  pas_out_if.source out_o,
  pas_cfg_if.sink  cfg_i
);

  logic [pas_pkg::LIMIT_W-1:0] limit_q;
  logic [pas_pkg::CMP_W-1:0]   limit_ext, cap;
  logic                        f_valid, f_ready, q_valid, q_ready;
  pas_pkg::pas_cmd_t           f_cmd, q_cmd;

  // capacity limit register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= pas_pkg::LIMIT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      limit_q <= cfg_i.capacity_limit;
    end
  end

  // effective capacity, clipped to the list depth
  assign limit_ext = pas_pkg::CMP_W'(limit_q);
  assign cap = (limit_ext > pas_pkg::CMP_W'(pas_pkg::DEPTH))
               ? pas_pkg::CMP_W'(pas_pkg::DEPTH) : limit_ext;

  pas_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  pas_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  pas_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .cap_i       (cap),
    .out_o       (out_o)
  );

endmodule

>>> rtl/core/pas_front.sv
// ---------------------------------------------------------------------------
// Positional array store - front end
// Accepts request items, decodes the operation and stages them for the queue.
// ---------------------------------------------------------------------------
module pas_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  pas_in_if.sink            in_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output pas_pkg::pas_cmd_t cmd_o
);

  logic              vld_q, vld_d;
  logic              take;
  pas_pkg::pas_cmd_t cmd_q;

  // stage is free when empty or draining into the queue this cycle
  assign in_i.ready = !vld_q || cmd_ready_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (cmd_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // decode and capture payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q.op       <= pas_pkg::pas_op_e'(in_i.operation);
      cmd_q.value    <= in_i.value;
      cmd_q.position <= in_i.position;
    end
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

>>> rtl/core/pas_queue.sv
// ---------------------------------------------------------------------------
// Positional array store - command queue
// Short FIFO that decouples the front end from the execution back end.
// ---------------------------------------------------------------------------
module pas_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  pas_pkg::pas_cmd_t push_cmd_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output pas_pkg::pas_cmd_t pop_cmd_o
);

  pas_pkg::pas_cmd_t                  slot_q [pas_pkg::QUEUE_DEPTH];
  logic [pas_pkg::QPTR_W-1:0]         wr_ptr_q, rd_ptr_q;
  logic [pas_pkg::QCNT_W-1:0]         fill_q;
  logic                               push, pop;

  assign push_ready_o = fill_q != pas_pkg::QCNT_W'(pas_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  function automatic logic [pas_pkg::QPTR_W-1:0] ptr_inc(
    input logic [pas_pkg::QPTR_W-1:0] ptr
  );
    if (ptr == pas_pkg::QPTR_W'(pas_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + 1'b1;
  endfunction

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/core/pas_exec.sv
// ---------------------------------------------------------------------------
// Positional array store - execution back end
// Register chain holding the list, the operation sequencer and the result
// register.
// ---------------------------------------------------------------------------
`include "positional_array_store_defines.svh"

module pas_exec (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  pas_pkg::pas_cmd_t              cmd_i,
  input  logic [pas_pkg::CMP_W-1:0]      cap_i,
  pas_out_if.source                      out_o
);

  localparam int CMP_W = pas_pkg::CMP_W;
  localparam int CNT_W = pas_pkg::CNT_W;
  localparam int IDX_W = pas_pkg::IDX_W;

  pas_pkg::pas_state_e                       state_q, state_d;
  logic [CNT_W-1:0]                          count_q, count_d;
  logic signed [pas_pkg::VALUE_W-1:0]        entries_q [pas_pkg::DEPTH];
  logic [pas_pkg::DEPTH-1:0]                 hit_q;
  logic [IDX_W-1:0]                          dump_idx_q;
  logic [CNT_W-1:0]                          dump_n_q, dump_n;
  logic                                      dump_last;
  logic                                      out_valid_q;
  pas_pkg::pas_result_t                      out_q, res;
  logic                                      out_free, out_load;
  logic                                      ins_en, del_en, hit_load;
  logic                                      dump_start, dump_adv;
  logic [CMP_W-1:0]                          pos_ext, cnt_ext;
  logic                                      found;
  logic [IDX_W-1:0]                          found_idx;

  assign out_free  = !out_valid_q || out_o.ready;
  assign pos_ext   = CMP_W'(cmd_i.position);
  assign cnt_ext   = CMP_W'(count_q);
  assign dump_last = (CNT_W'(dump_idx_q) + CNT_W'(1)) == dump_n_q;

  // dump length, clipped to the result limit
  assign dump_n = (cnt_ext > CMP_W'(pas_pkg::MAX_RESULTS))
                  ? CNT_W'(pas_pkg::MAX_RESULTS) : count_q;

  // lowest matching index from the registered hit vector
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = pas_pkg::DEPTH - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  // sequencer outputs
  always_comb begin
    cmd_ready_o     = 1'b0;
    ins_en          = 1'b0;
    del_en          = 1'b0;
    hit_load        = 1'b0;
    dump_start      = 1'b0;
    dump_adv        = 1'b0;
    out_load        = 1'b0;
    count_d         = count_q;
    res.status      = pas_pkg::ST_OK;
    res.index       = '0;
    res.entry_value = '0;
    res.last        = 1'b1;
    unique case (state_q)
      pas_pkg::S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          if (cmd_i.op == pas_pkg::OP_INSERT) begin
            out_load = 1'b1;
            if (cnt_ext >= cap_i) begin
              res.status = pas_pkg::ST_FULL;
            end else if (pos_ext > cnt_ext) begin
              res.status = pas_pkg::ST_BADPOS;
            end else begin
              ins_en  = 1'b1;
              count_d = count_q + 1'b1;
            end
          end else if (count_q == '0) begin
            out_load   = 1'b1;
            res.status = pas_pkg::ST_EMPTY;
          end else begin
            unique case (cmd_i.op)
              pas_pkg::OP_DELETE: begin
                out_load = 1'b1;
                if (pos_ext >= cnt_ext) begin
                  res.status = pas_pkg::ST_BADPOS;
                end else begin
                  del_en  = 1'b1;
                  count_d = count_q - 1'b1;
                end
              end
              pas_pkg::OP_SEARCH: hit_load   = 1'b1;
              pas_pkg::OP_DUMP:   dump_start = 1'b1;
              default: ;
            endcase
          end
        end
      end
      pas_pkg::S_SEARCH: begin
        if (out_free) begin
          out_load   = 1'b1;
          res.status = found ? pas_pkg::ST_OK : pas_pkg::ST_NOTFOUND;
          res.index  = found ? pas_pkg::OUT_IDX_W'(found_idx) : '0;
        end
      end
      pas_pkg::S_DUMP: begin
        if (out_free) begin
          out_load        = 1'b1;
          dump_adv        = 1'b1;
          res.index       = pas_pkg::OUT_IDX_W'(dump_idx_q);
          res.entry_value = entries_q[dump_idx_q];
          res.last        = dump_last;
        end
      end
      default: ;
    endcase
    res.entry_count = pas_pkg::OUT_CNT_W'(count_d);
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pas_pkg::S_IDLE: begin
        if (hit_load) begin
          state_d = pas_pkg::S_SEARCH;
        end else if (dump_start) begin
          state_d = pas_pkg::S_DUMP;
        end
      end
      pas_pkg::S_SEARCH: begin
        if (out_free) begin
          state_d = pas_pkg::S_IDLE;
        end
      end
      pas_pkg::S_DUMP: begin
        if (out_free && dump_last) begin
          state_d = pas_pkg::S_IDLE;
        end
      end
      default: state_d = pas_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pas_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      dump_idx_q  <= '0;
      dump_n_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (dump_start) begin
        dump_idx_q <= '0;
        dump_n_q   <= dump_n;
      end else if (dump_adv) begin
        dump_idx_q <= IDX_W'(dump_idx_q + 1'b1);
      end
    end
  end

  // result register and search hit vector
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
    if (hit_load) begin
      for (int i = 0; i < pas_pkg::DEPTH; i++) begin
        hit_q[i] <= (entries_q[i] == cmd_i.value) && (CNT_W'(i) < count_q);
      end
    end
  end

  // list cells: each shifts from a neighbor or takes the inserted value
  for (genvar g = 0; g < pas_pkg::DEPTH; g++) begin : g_cell
    logic signed [pas_pkg::VALUE_W-1:0] below_w, above_w;
    logic                               at_pos, past_pos;

    if (g == 0) begin : g_first
      assign below_w = '0;
    end else begin : g_below
      assign below_w = entries_q[g-1];
    end
    if (g == pas_pkg::DEPTH - 1) begin : g_last
      assign above_w = entries_q[g];
    end else begin : g_above
      assign above_w = entries_q[g+1];
    end

    assign at_pos   = CMP_W'(g) == pos_ext;
    assign past_pos = CMP_W'(g) > pos_ext;

    always_ff @(posedge clk_i) begin
      if (ins_en) begin
        if (at_pos) begin
          entries_q[g] <= cmd_i.value;
        end else if (past_pos) begin
          entries_q[g] <= below_w;
        end
      end else if (del_en && (at_pos || past_pos)) begin
        entries_q[g] <= above_w;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_q.status;
  assign out_o.index       = out_q.index;
  assign out_o.entry_value = out_q.entry_value;
  assign out_o.entry_count = out_q.entry_count;
  assign out_o.last        = out_q.last;

  // checks
  `PAS_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(pas_pkg::DEPTH))
  `PAS_ASSERT_NEXT(a_search_reply, clk_i, rst_ni, state_q == pas_pkg::S_SEARCH && out_free, out_valid_q)
  `PAS_ASSERT_ALWAYS(a_dump_range, clk_i, rst_ni, state_q != pas_pkg::S_DUMP || CNT_W'(dump_idx_q) < dump_n_q)
  `PAS_ASSERT_NEXT(a_count_step, clk_i, rst_ni, 1'b1, count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1)

endmodule
